// ----- design/lpc_pkg.sv -----
// Shared types, widths and helper functions for the line position centroid unit.
// Depends on nothing; every other design file imports it.
package lpc_pkg;

    localparam int CHANNEL_COUNT  = 8;
    localparam int SAMPLE_BITS    = 10;
    localparam int LANE_BITS      = $clog2(CHANNEL_COUNT);
    localparam int COUNT_BITS     = $clog2(CHANNEL_COUNT + 1);
    localparam int CFG_DATA_BITS  = 40;
    localparam int CFG_INDEX_BITS = 3;
    localparam int POS_BITS       = 16;
    localparam int Q_SHIFT        = 14;

    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int WU_BITS     = SAMPLE_BITS + LANE_BITS;
    localparam int USUM_BITS   = SAMPLE_BITS + COUNT_BITS;
    localparam int WRANK_BITS  = SAMPLE_BITS + $clog2(CHANNEL_COUNT * (CHANNEL_COUNT - 1) / 2 + 1);
    localparam int WEIGHT_BITS = WRANK_BITS + SAMPLE_BITS;
    localparam int AVG_BITS    = WU_BITS;
    localparam int QUO_BITS    = Q_SHIFT + 1;

    // register ranks from the accepting edge to the edge that takes the result
    localparam int PIPE_LATENCY = (SAMPLE_BITS + 2) + (SAMPLE_BITS + 3) + (AVG_BITS + QUO_BITS + 4);

    localparam logic [SAMPLE_BITS-1:0] MAXV  = '1;
    localparam logic [POS_BITS-1:0]    Q_ONE = POS_BITS'(1) << Q_SHIFT;

    typedef logic [CHANNEL_COUNT-1:0][SAMPLE_BITS-1:0] t_lane_vec;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_READ_ERR = 2'd1,
        ST_BELOW    = 2'd2,
        ST_DEGEN    = 2'd3
    } t_status;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_LOW    = 3'd0,
        CFG_MIN_HIGH   = 3'd1,
        CFG_RANGE_LOW  = 3'd2,
        CFG_RANGE_HIGH = 3'd3,
        CFG_MASK       = 3'd4,
        CFG_WHITE      = 3'd5,
        CFG_THRESHOLD  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_lane_vec                cal_min;
        t_lane_vec                cal_range;
        logic [CHANNEL_COUNT-1:0] mask;
        logic                     white;
        logic [SAMPLE_BITS-1:0]   thresh;
    } t_cfg;

    typedef struct packed {
        logic    valid;
        t_status code;
    } t_tag;

    // position of a channel among the enabled ones
    function automatic logic [LANE_BITS-1:0] lane_rank(input logic [CHANNEL_COUNT-1:0] mask,
                                                       input int unsigned ch);
        logic [LANE_BITS-1:0] cnt;
        cnt = '0;
        for (int b = 0; b < CHANNEL_COUNT; b++) begin
            if ((b < ch) && mask[b]) begin
                cnt = cnt + LANE_BITS'(1);
            end
        end
        return cnt;
    endfunction

    function automatic logic [COUNT_BITS-1:0] chan_count(input logic [CHANNEL_COUNT-1:0] mask);
        logic [COUNT_BITS-1:0] cnt;
        cnt = '0;
        for (int b = 0; b < CHANNEL_COUNT; b++) begin
            cnt = cnt + COUNT_BITS'(mask[b]);
        end
        return cnt;
    endfunction

    // array middle in counts: (n - 1) * MAXV / 2
    function automatic logic [AVG_BITS-1:0] middle_of(input logic [COUNT_BITS-1:0] n);
        logic [AVG_BITS-1:0] span;
        span = (n == '0) ? '0 : AVG_BITS'(n - COUNT_BITS'(1)) * AVG_BITS'(MAXV);
        return span >> 1;
    endfunction

endpackage

// ----- design/line_position_centroid_unit.sv -----
// Pipeline: the result strobe o_done comes out of 57 register ranks behind the edge that accepts
// an item: calibration divider, renormalization divider, two centroid dividers.
// Throughput: one item per clock; every divider retires one quotient bit per stage.
// Reset: synchronous, active low; clears all stage valid bits and restores register defaults.
// o_busy is high only during reset; the result side cannot stall, so nothing else holds items.
// Configuration writes are taken every cycle out of reset; write only while the pipe is empty.
module line_position_centroid_unit import lpc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [SAMPLE_BITS-1:0]     i_sample_0,
    input  logic [SAMPLE_BITS-1:0]     i_sample_1,
    input  logic [SAMPLE_BITS-1:0]     i_sample_2,
    input  logic [SAMPLE_BITS-1:0]     i_sample_3,
    input  logic [SAMPLE_BITS-1:0]     i_sample_4,
    input  logic [SAMPLE_BITS-1:0]     i_sample_5,
    input  logic [SAMPLE_BITS-1:0]     i_sample_6,
    input  logic [SAMPLE_BITS-1:0]     i_sample_7,
    input  logic                       i_read_ok,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic signed [POS_BITS-1:0] o_position
);
    // configuration registers
    logic [CFG_DATA_BITS-1:0] r_min_low;
    logic [CFG_DATA_BITS-1:0] r_min_high;
    logic [CFG_DATA_BITS-1:0] r_range_low;
    logic [CFG_DATA_BITS-1:0] r_range_high;
    logic [CHANNEL_COUNT-1:0] r_mask;
    logic                     r_white;
    logic [SAMPLE_BITS-1:0]   r_thresh;
    logic                     r_busy;
    logic                     r_cfg_ready;

    t_cfg      w_cfg;
    t_lane_vec w_sample;
    logic      w_accept;
    t_tag      w_cal_tag;
    t_lane_vec w_level;
    t_tag      w_norm_tag;
    t_lane_vec w_unit;
    t_tag      w_out_tag;

    logic [2*CFG_DATA_BITS-1:0] w_min_all;
    logic [2*CFG_DATA_BITS-1:0] w_range_all;

    assign w_accept = i_start && !r_busy;
    assign w_sample = {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                       i_sample_3, i_sample_2, i_sample_1, i_sample_0};

    // channel fields sit side by side, low register first
    assign w_min_all   = {r_min_high, r_min_low};
    assign w_range_all = {r_range_high, r_range_low};
    always_comb begin
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            w_cfg.cal_min[ch]   = w_min_all[ch*SAMPLE_BITS +: SAMPLE_BITS];
            w_cfg.cal_range[ch] = w_range_all[ch*SAMPLE_BITS +: SAMPLE_BITS];
        end
        w_cfg.mask   = r_mask;
        w_cfg.white  = r_white;
        w_cfg.thresh = r_thresh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_low    <= '0;
            r_min_high   <= '0;
            r_range_low  <= '1;
            r_range_high <= '1;
            r_mask       <= '1;
            r_white      <= 1'b0;
            r_thresh     <= '0;
            r_busy       <= 1'b1;
            r_cfg_ready  <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_LOW:    r_min_low    <= i_cfg_data;
                    CFG_MIN_HIGH:   r_min_high   <= i_cfg_data;
                    CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                    CFG_MASK:       r_mask       <= i_cfg_data[CHANNEL_COUNT-1:0];
                    CFG_WHITE:      r_white      <= i_cfg_data[0];
                    CFG_THRESHOLD:  r_thresh     <= i_cfg_data[SAMPLE_BITS-1:0];
                    default:        ; // drop writes to unmapped indexes
                endcase
            end
        end
    end

    // calibrate each enabled channel
    lpc_calib u_calib (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_sample  (w_sample),
        .i_read_ok (i_read_ok),
        .i_cfg     (w_cfg),
        .o_tag     (w_cal_tag),
        .o_level   (w_level)
    );

    // threshold check and renormalize to the scan's own spread
    lpc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_cal_tag),
        .i_level (w_level),
        .i_cfg   (w_cfg),
        .o_tag   (w_norm_tag),
        .o_unit  (w_unit)
    );

    // weighted centroid, centered and scaled to Q1.14
    lpc_centroid u_centroid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_norm_tag),
        .i_unit     (w_unit),
        .i_cfg      (w_cfg),
        .o_tag      (w_out_tag),
        .o_position (o_position)
    );

    assign o_busy      = r_busy;
    assign o_cfg_ready = r_cfg_ready;
    assign o_done      = w_out_tag.valid;
    assign o_status    = w_out_tag.code;

    // every result strobe traces back to an item taken a fixed latency earlier
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, PIPE_LATENCY))
        else $error("result strobe without a matching accepted item");

    // position carries a value only when a line was found
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_FOUND)) |-> (o_position == '0))
        else $error("nonzero position with a failure status");

    // position saturates at plus or minus one
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_position <= $signed(Q_ONE)) && (o_position >= -$signed(Q_ONE))))
        else $error("position outside Q1.14 unit range");

    // the unit takes items in the cycle right after reset releases
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (!o_busy && o_cfg_ready))
        else $error("busy or config stall outside reset");

endmodule

// ----- design/lpc_calib.sv -----
// Channel gather and calibration: (raw - min) * MAXV / range, clamped, optional invert.
// Bit-serial restoring division, one quotient bit per stage. Uses lpc_pkg.
module lpc_calib import lpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_lane_vec i_sample,
    input  logic      i_read_ok,
    input  t_cfg      i_cfg,
    output t_tag      o_tag,
    output t_lane_vec o_level
);
    localparam int STEPS = SAMPLE_BITS;

    logic                     r_valid [STEPS+1];
    t_status                  r_code  [STEPS+1];
    t_lane_vec                r_rem   [STEPS+1];
    t_lane_vec                r_low   [STEPS+1];
    t_lane_vec                r_quo   [STEPS+1];
    logic [CHANNEL_COUNT-1:0] r_zero  [STEPS+1];
    logic [CHANNEL_COUNT-1:0] r_sat   [STEPS+1];
    t_tag                     r_tag;
    t_lane_vec                r_level;

    t_lane_vec                               n_raw;
    t_lane_vec                               n_diff;
    t_lane_vec                               n_cal;
    logic [CHANNEL_COUNT-1:0][PROD_BITS-1:0] n_prod;
    logic [CHANNEL_COUNT-1:0][SAMPLE_BITS:0] n_trial [STEPS];

    always_comb begin
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            n_raw[ch]  = i_sample[lane_rank(i_cfg.mask, ch)];
            n_diff[ch] = n_raw[ch] - i_cfg.cal_min[ch];
            n_prod[ch] = (PROD_BITS'(n_diff[ch]) << SAMPLE_BITS) - PROD_BITS'(n_diff[ch]);
        end
        for (int k = 0; k < STEPS; k++) begin
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                n_trial[k][ch] = {r_rem[k][ch], r_low[k][ch][SAMPLE_BITS-1]};
            end
        end
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            if (r_zero[STEPS][ch]) begin
                n_cal[ch] = '0;
            end else if (r_sat[STEPS][ch]) begin
                n_cal[ch] = MAXV;
            end else begin
                n_cal[ch] = r_quo[STEPS][ch];
            end
            if (i_cfg.white) begin
                n_cal[ch] = MAXV - n_cal[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_tag.valid <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            r_tag.valid <= r_valid[STEPS];
        end

        r_code[0] <= (i_read_ok && (i_cfg.mask != '0)) ? ST_FOUND : ST_READ_ERR;
        r_quo[0]  <= '0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            r_rem[0][ch]  <= n_prod[ch][PROD_BITS-1 -: SAMPLE_BITS];
            r_low[0][ch]  <= n_prod[ch][SAMPLE_BITS-1:0];
            r_zero[0][ch] <= (n_raw[ch] <= i_cfg.cal_min[ch]);
            r_sat[0][ch]  <= (n_prod[ch][PROD_BITS-1 -: SAMPLE_BITS] >= i_cfg.cal_range[ch]);
        end

        for (int k = 1; k <= STEPS; k++) begin
            r_code[k] <= r_code[k-1];
            r_zero[k] <= r_zero[k-1];
            r_sat[k]  <= r_sat[k-1];
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                r_low[k][ch] <= r_low[k-1][ch] << 1;
                if (n_trial[k-1][ch] >= {1'b0, i_cfg.cal_range[ch]}) begin
                    r_rem[k][ch] <= SAMPLE_BITS'(n_trial[k-1][ch] - {1'b0, i_cfg.cal_range[ch]});
                    r_quo[k][ch] <= {r_quo[k-1][ch][SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k][ch] <= n_trial[k-1][ch][SAMPLE_BITS-1:0];
                    r_quo[k][ch] <= {r_quo[k-1][ch][SAMPLE_BITS-2:0], 1'b0};
                end
            end
        end

        r_tag.code <= r_code[STEPS];
        r_level    <= n_cal;
    end

    assign o_tag   = r_tag;
    assign o_level = r_level;

endmodule

// ----- design/lpc_norm.sv -----
// Peak and spread check, then renormalization (v - lo) * MAXV / spread per lane.
// Bit-serial restoring division, one quotient bit per stage. Uses lpc_pkg.
module lpc_norm import lpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tag      i_tag,
    input  t_lane_vec i_level,
    input  t_cfg      i_cfg,
    output t_tag      o_tag,
    output t_lane_vec o_unit
);
    localparam int STEPS = SAMPLE_BITS;

    // min / max rank
    logic                   r_v1;
    t_status                r_c1;
    t_lane_vec              r_lvl1;
    logic [SAMPLE_BITS-1:0] r_lo1;
    logic [SAMPLE_BITS-1:0] r_hi1;

    // divider ranks
    logic                   r_valid [STEPS+1];
    t_status                r_code  [STEPS+1];
    t_lane_vec              r_rem   [STEPS+1];
    t_lane_vec              r_low   [STEPS+1];
    t_lane_vec              r_quo   [STEPS+1];
    logic [SAMPLE_BITS-1:0] r_div   [STEPS+1];
    logic                   r_zero  [STEPS+1];
    t_tag                   r_tag;
    t_lane_vec              r_unit;

    logic [SAMPLE_BITS-1:0]                  n_lo;
    logic [SAMPLE_BITS-1:0]                  n_hi;
    logic [SAMPLE_BITS-1:0]                  n_spread;
    logic                                    n_below;
    t_lane_vec                               n_diff;
    logic [CHANNEL_COUNT-1:0][PROD_BITS-1:0] n_prod;
    logic [CHANNEL_COUNT-1:0][SAMPLE_BITS:0] n_trial [STEPS];

    always_comb begin
        n_lo = MAXV;
        n_hi = '0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            if (i_cfg.mask[ch]) begin
                if (i_level[ch] < n_lo) n_lo = i_level[ch];
                if (i_level[ch] > n_hi) n_hi = i_level[ch];
            end
        end
        n_spread = r_hi1 - r_lo1;
        n_below  = (r_hi1 < i_cfg.thresh) || (n_spread < i_cfg.thresh);
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            n_diff[ch] = r_lvl1[ch] - r_lo1;
            n_prod[ch] = (PROD_BITS'(n_diff[ch]) << SAMPLE_BITS) - PROD_BITS'(n_diff[ch]);
        end
        for (int k = 0; k < STEPS; k++) begin
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                n_trial[k][ch] = {r_rem[k][ch], r_low[k][ch][SAMPLE_BITS-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int k = 0; k <= STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_tag.valid <= 1'b0;
        end else begin
            r_v1       <= i_tag.valid;
            r_valid[0] <= r_v1;
            for (int k = 1; k <= STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            r_tag.valid <= r_valid[STEPS];
        end

        r_c1   <= i_tag.code;
        r_lvl1 <= i_level;
        r_lo1  <= n_lo;
        r_hi1  <= n_hi;

        r_code[0] <= ((r_c1 == ST_FOUND) && n_below) ? ST_BELOW : r_c1;
        r_div[0]  <= n_spread;
        r_zero[0] <= (n_spread == '0);
        r_quo[0]  <= '0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            r_rem[0][ch] <= n_prod[ch][PROD_BITS-1 -: SAMPLE_BITS];
            r_low[0][ch] <= n_prod[ch][SAMPLE_BITS-1:0];
        end

        for (int k = 1; k <= STEPS; k++) begin
            r_code[k] <= r_code[k-1];
            r_div[k]  <= r_div[k-1];
            r_zero[k] <= r_zero[k-1];
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                r_low[k][ch] <= r_low[k-1][ch] << 1;
                if (n_trial[k-1][ch] >= {1'b0, r_div[k-1]}) begin
                    r_rem[k][ch] <= SAMPLE_BITS'(n_trial[k-1][ch] - {1'b0, r_div[k-1]});
                    r_quo[k][ch] <= {r_quo[k-1][ch][SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k][ch] <= n_trial[k-1][ch][SAMPLE_BITS-1:0];
                    r_quo[k][ch] <= {r_quo[k-1][ch][SAMPLE_BITS-2:0], 1'b0};
                end
            end
        end

        r_tag.code <= r_code[STEPS];
        r_unit     <= r_zero[STEPS] ? '0 : r_quo[STEPS];
    end

    assign o_tag  = r_tag;
    assign o_unit = r_unit;

endmodule

// ----- design/lpc_centroid.sv -----
// Weighted sum, centroid division and Q1.14 scaling against the array middle.
// Two bit-serial restoring dividers in series. Uses lpc_pkg.
module lpc_centroid import lpc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tag                       i_tag,
    input  t_lane_vec                  i_unit,
    input  t_cfg                       i_cfg,
    output t_tag                       o_tag,
    output logic signed [POS_BITS-1:0] o_position
);
    // weighting rank
    logic                                  r_v1;
    t_status                               r_c1;
    logic [CHANNEL_COUNT-1:0][WU_BITS-1:0] r_wu1;
    logic [USUM_BITS-1:0]                  r_usum1;

    // centroid divider: weighted / sum
    logic                 ra_valid [AVG_BITS+1];
    t_status              ra_code  [AVG_BITS+1];
    logic [USUM_BITS-1:0] ra_rem   [AVG_BITS+1];
    logic [AVG_BITS-1:0]  ra_low   [AVG_BITS+1];
    logic [AVG_BITS-1:0]  ra_quo   [AVG_BITS+1];
    logic [USUM_BITS-1:0] ra_div   [AVG_BITS+1];

    // scaling divider: |rel| * 2^14 / middle
    logic                 rb_valid [QUO_BITS+1];
    t_status              rb_code  [QUO_BITS+1];
    logic [AVG_BITS-1:0]  rb_rem   [QUO_BITS+1];
    logic [QUO_BITS-1:0]  rb_low   [QUO_BITS+1];
    logic [QUO_BITS-1:0]  rb_quo   [QUO_BITS+1];
    logic [AVG_BITS-1:0]  rb_div   [QUO_BITS+1];
    logic                 rb_neg   [QUO_BITS+1];
    logic                 rb_sat   [QUO_BITS+1];

    t_tag                       r_tag;
    logic signed [POS_BITS-1:0] r_position;

    logic [CHANNEL_COUNT-1:0][WU_BITS-1:0] n_wu;
    logic [USUM_BITS-1:0]                  n_usum;
    logic [WRANK_BITS-1:0]                 n_wsum;
    logic [WEIGHT_BITS-1:0]                n_weighted;
    logic [COUNT_BITS-1:0]                 n_count;
    logic [AVG_BITS-1:0]                   n_mid;
    logic [AVG_BITS-1:0]                   n_avg;
    logic                                  n_neg;
    logic [AVG_BITS-1:0]                   n_mag;
    logic [USUM_BITS:0]                    n_trial_a [AVG_BITS];
    logic [AVG_BITS:0]                     n_trial_b [QUO_BITS];
    logic [QUO_BITS:0]                     n_ceil;
    logic [POS_BITS-1:0]                   n_abs;

    always_comb begin
        n_usum = '0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            n_wu[ch] = i_cfg.mask[ch]
                     ? WU_BITS'(i_unit[ch]) * WU_BITS'(lane_rank(i_cfg.mask, ch)) : '0;
            if (i_cfg.mask[ch]) begin
                n_usum = n_usum + USUM_BITS'(i_unit[ch]);
            end
        end

        n_wsum = '0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            n_wsum = n_wsum + WRANK_BITS'(r_wu1[ch]);
        end
        n_weighted = (WEIGHT_BITS'(n_wsum) << SAMPLE_BITS) - WEIGHT_BITS'(n_wsum);
        n_count    = chan_count(i_cfg.mask);
        n_mid      = middle_of(n_count);

        for (int k = 0; k < AVG_BITS; k++) begin
            n_trial_a[k] = {ra_rem[k], ra_low[k][AVG_BITS-1]};
        end

        n_avg = ra_quo[AVG_BITS];
        n_neg = (n_avg < n_mid);
        n_mag = n_neg ? (n_mid - n_avg) : (n_avg - n_mid);

        for (int k = 0; k < QUO_BITS; k++) begin
            n_trial_b[k] = {rb_rem[k], rb_low[k][QUO_BITS-1]};
        end

        // negative side floors away from zero: round the magnitude up
        n_ceil = {1'b0, rb_quo[QUO_BITS]}
               + (QUO_BITS+1)'(rb_neg[QUO_BITS] && (rb_rem[QUO_BITS] != '0));
        if (rb_sat[QUO_BITS] || (n_ceil > (QUO_BITS+1)'(Q_ONE))) begin
            n_abs = Q_ONE;
        end else begin
            n_abs = POS_BITS'(n_ceil);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int k = 0; k <= AVG_BITS; k++) begin
                ra_valid[k] <= 1'b0;
            end
            for (int k = 0; k <= QUO_BITS; k++) begin
                rb_valid[k] <= 1'b0;
            end
            r_tag.valid <= 1'b0;
        end else begin
            r_v1        <= i_tag.valid;
            ra_valid[0] <= r_v1;
            for (int k = 1; k <= AVG_BITS; k++) begin
                ra_valid[k] <= ra_valid[k-1];
            end
            rb_valid[0] <= ra_valid[AVG_BITS];
            for (int k = 1; k <= QUO_BITS; k++) begin
                rb_valid[k] <= rb_valid[k-1];
            end
            r_tag.valid <= rb_valid[QUO_BITS];
        end

        r_c1    <= i_tag.code;
        r_wu1   <= n_wu;
        r_usum1 <= n_usum;

        ra_code[0] <= ((r_c1 == ST_FOUND) && ((r_usum1 == '0) || (n_count < COUNT_BITS'(2))))
                    ? ST_DEGEN : r_c1;
        ra_rem[0]  <= USUM_BITS'(n_weighted >> AVG_BITS);
        ra_low[0]  <= n_weighted[AVG_BITS-1:0];
        ra_quo[0]  <= '0;
        ra_div[0]  <= r_usum1;
        for (int k = 1; k <= AVG_BITS; k++) begin
            ra_code[k] <= ra_code[k-1];
            ra_div[k]  <= ra_div[k-1];
            ra_low[k]  <= ra_low[k-1] << 1;
            if (n_trial_a[k-1] >= {1'b0, ra_div[k-1]}) begin
                ra_rem[k] <= USUM_BITS'(n_trial_a[k-1] - {1'b0, ra_div[k-1]});
                ra_quo[k] <= {ra_quo[k-1][AVG_BITS-2:0], 1'b1};
            end else begin
                ra_rem[k] <= n_trial_a[k-1][USUM_BITS-1:0];
                ra_quo[k] <= {ra_quo[k-1][AVG_BITS-2:0], 1'b0};
            end
        end

        rb_code[0] <= ra_code[AVG_BITS];
        rb_rem[0]  <= n_mag >> 1;
        rb_low[0]  <= {n_mag[0], {Q_SHIFT{1'b0}}};
        rb_quo[0]  <= '0;
        rb_div[0]  <= n_mid;
        rb_neg[0]  <= n_neg;
        rb_sat[0]  <= ((n_mag >> 1) >= n_mid);
        for (int k = 1; k <= QUO_BITS; k++) begin
            rb_code[k] <= rb_code[k-1];
            rb_div[k]  <= rb_div[k-1];
            rb_neg[k]  <= rb_neg[k-1];
            rb_sat[k]  <= rb_sat[k-1];
            rb_low[k]  <= rb_low[k-1] << 1;
            if (n_trial_b[k-1] >= {1'b0, rb_div[k-1]}) begin
                rb_rem[k] <= AVG_BITS'(n_trial_b[k-1] - {1'b0, rb_div[k-1]});
                rb_quo[k] <= {rb_quo[k-1][QUO_BITS-2:0], 1'b1};
            end else begin
                rb_rem[k] <= n_trial_b[k-1][AVG_BITS-1:0];
                rb_quo[k] <= {rb_quo[k-1][QUO_BITS-2:0], 1'b0};
            end
        end

        r_tag.code <= rb_code[QUO_BITS];
        if (rb_code[QUO_BITS] != ST_FOUND) begin
            r_position <= '0;
        end else if (rb_neg[QUO_BITS]) begin
            r_position <= -$signed(n_abs);
        end else begin
            r_position <= $signed(n_abs);
        end
    end

    assign o_tag      = r_tag;
    assign o_position = r_position;

endmodule

// ----- tb/lpc_checker.sv -----
// Checker for the line position centroid unit: mirrors config writes, predicts each scan result.
// Depends on lpc_pkg for widths, status codes and register indexes.
module lpc_checker import lpc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [SAMPLE_BITS-1:0]     i_sample_0,
    input  logic [SAMPLE_BITS-1:0]     i_sample_1,
    input  logic [SAMPLE_BITS-1:0]     i_sample_2,
    input  logic [SAMPLE_BITS-1:0]     i_sample_3,
    input  logic [SAMPLE_BITS-1:0]     i_sample_4,
    input  logic [SAMPLE_BITS-1:0]     i_sample_5,
    input  logic [SAMPLE_BITS-1:0]     i_sample_6,
    input  logic [SAMPLE_BITS-1:0]     i_sample_7,
    input  logic                       i_read_ok,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                       i_done,
    input  logic [1:0]                 i_status,
    input  logic signed [POS_BITS-1:0] i_position,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                 status;
        logic signed [POS_BITS-1:0] position;
    } t_scan_result;

    logic [39:0]              min_lo, min_hi, rng_lo, rng_hi;
    logic [7:0]               mask_r;
    logic                     white_r;
    logic [9:0]               thresh_r;
    t_scan_result             expected_scans[$];

    assign o_pending = expected_scans.size();

    function automatic t_scan_result centroid_of(input logic [7:0][9:0] raw, input logic ok);
        t_scan_result r;
        longint v[8];
        longint n, lo, hi, spread, mn, rg, c, u, wsum, usum, middle, rel, pos, num;
        logic [39:0] mreg, rreg;
        n = 0;
        r.status = ST_READ_ERR;
        r.position = '0;
        if (!ok || mask_r == 0) return r;
        for (int ch = 0; ch < 8; ch++) begin
            if (mask_r[ch]) begin
                mreg = (ch < 4) ? min_lo : min_hi;
                rreg = (ch < 4) ? rng_lo : rng_hi;
                mn = (mreg >> ((ch % 4) * 10)) & 10'h3FF;
                rg = (rreg >> ((ch % 4) * 10)) & 10'h3FF;
                if (raw[n] <= mn) c = 0;
                else if (rg == 0) c = 1023;
                else begin
                    c = (raw[n] - mn) * 1023 / rg;
                    if (c > 1023) c = 1023;
                end
                if (white_r) c = 1023 - c;
                v[n] = c;
                n++;
            end
        end
        lo = 1023;
        hi = 0;
        for (int i = 0; i < n; i++) begin
            if (v[i] < lo) lo = v[i];
            if (v[i] > hi) hi = v[i];
        end
        spread = hi - lo;
        if (hi < thresh_r || spread < thresh_r) begin
            r.status = ST_BELOW;
            return r;
        end
        wsum = 0;
        usum = 0;
        if (spread != 0) begin
            for (int i = 0; i < n; i++) begin
                u = (v[i] - lo) * 1023 / spread;
                wsum += u * i * 1023;
                usum += u;
            end
        end
        middle = (n - 1) * 1023 / 2;
        if (usum == 0 || middle == 0) begin
            r.status = ST_DEGEN;
            return r;
        end
        rel = wsum / usum - middle;
        num = rel * 16384;
        // floor division toward minus infinity
        pos = num / middle;
        if ((num % middle != 0) && (num < 0)) pos -= 1;
        if (pos > 16384) pos = 16384;
        if (pos < -16384) pos = -16384;
        r.status = ST_FOUND;
        r.position = POS_BITS'(pos);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result got, want;
        if (!i_rst_n) begin
            min_lo <= '0;
            min_hi <= '0;
            rng_lo <= '1;
            rng_hi <= '1;
            mask_r <= 8'hFF;
            white_r <= 1'b0;
            thresh_r <= '0;
            o_fail_count <= 0;
            expected_scans.delete();
        end else begin
            if (i_done) begin
                got.status = i_status;
                got.position = i_position;
                if (expected_scans.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result status=%0d", i_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_scans.pop_front();
                    if (got.status !== want.status || got.position !== want.position) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp status=%0d pos=%0d got status=%0d pos=%0d",
                                     want.status, want.position, got.status, got.position);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_scans.push_back(centroid_of({i_sample_7, i_sample_6, i_sample_5,
                    i_sample_4, i_sample_3, i_sample_2, i_sample_1, i_sample_0}, i_read_ok));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_LOW:    min_lo <= i_cfg_data;
                    CFG_MIN_HIGH:   min_hi <= i_cfg_data;
                    CFG_RANGE_LOW:  rng_lo <= i_cfg_data;
                    CFG_RANGE_HIGH: rng_hi <= i_cfg_data;
                    CFG_MASK:       mask_r <= i_cfg_data[7:0];
                    CFG_WHITE:      white_r <= i_cfg_data[0];
                    CFG_THRESHOLD:  thresh_r <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- tb/tb_line_position_centroid_unit.sv -----
// Top of the line position centroid unit testbench: clock, reset, scan and register stimulus.
// Depends on lpc_pkg, the unit itself and lpc_checker, which predicts and counts failures.
module tb_line_position_centroid_unit;
    import lpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
    localparam int STALL_LIMIT  = 2000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_start = 1'b0;
    logic                       o_busy;
    logic [SAMPLE_BITS-1:0]     i_sample [8];
    logic                       i_read_ok = 1'b1;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data = '0;
    logic                       o_done;
    logic [1:0]                 o_status;
    logic signed [POS_BITS-1:0] o_position;
    int                         fail_count, pending;
    int                         idle_cycles = 0;

    initial for (int k = 0; k < 8; k++) i_sample[k] = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_position_centroid_unit DUT (
        .i_clk, .i_rst_n, .i_start, .o_busy,
        .i_sample_0(i_sample[0]), .i_sample_1(i_sample[1]), .i_sample_2(i_sample[2]),
        .i_sample_3(i_sample[3]), .i_sample_4(i_sample[4]), .i_sample_5(i_sample[5]),
        .i_sample_6(i_sample[6]), .i_sample_7(i_sample[7]), .i_read_ok,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_done, .o_status, .o_position
    );

    lpc_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_sample_0(i_sample[0]), .i_sample_1(i_sample[1]), .i_sample_2(i_sample[2]),
        .i_sample_3(i_sample[3]), .i_sample_4(i_sample[4]), .i_sample_5(i_sample[5]),
        .i_sample_6(i_sample[6]), .i_sample_7(i_sample[7]), .i_read_ok,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_done(o_done), .i_status(o_status), .i_position(o_position),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: count cycles in which neither a scan, a register write nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_line_position_centroid_unit failed");
            $finish;
        end
    end

    // Gap before an item: mostly none or short, now and then long.
    // Drop start only when a gap is really taken.
    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return;
        i_start <= 1'b0;
        repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge i_clk);
    endtask

    // Write one register, holding valid until the port takes it, then drop valid.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain the pipe fully so register writes never overlap a scan in flight.
    task automatic drain();
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Present one scan and hold start until the unit takes it; start stays high for the
    // next scan unless a gap or a drain drops it.
    task automatic send_scan(input logic [7:0][9:0] s, input logic ok, input bit gaps);
        if (gaps) idle_gap();
        i_start <= 1'b1;
        for (int k = 0; k < 8; k++) i_sample[k] <= s[k];
        i_read_ok <= ok;
        do @(posedge i_clk); while (o_busy);
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(0, 255)), $urandom()};
    endfunction

    // Pick min/range around a typical spread, with extreme values now and then; also mask, white, threshold.
    task automatic random_settings();
        logic [39:0] mn [2], rg [2];
        for (int h = 0; h < 2; h++) begin
            for (int c = 0; c < 4; c++) begin
                case ($urandom_range(0, 5))
                    0: begin mn[h][c*10 +: 10] = '0;   rg[h][c*10 +: 10] = '1; end
                    1: begin mn[h][c*10 +: 10] = 10'($urandom()); rg[h][c*10 +: 10] = '0; end
                    default: begin
                        mn[h][c*10 +: 10] = 10'($urandom_range(0, 300));
                        rg[h][c*10 +: 10] = 10'($urandom_range(200, 1023));
                    end
                endcase
            end
            if ($urandom_range(0, 7) == 0) mn[h] = rand40();
            if ($urandom_range(0, 7) == 0) rg[h] = rand40();
        end
        write_reg(CFG_MIN_LOW, mn[0]);
        write_reg(CFG_MIN_HIGH, mn[1]);
        write_reg(CFG_RANGE_LOW, rg[0]);
        write_reg(CFG_RANGE_HIGH, rg[1]);
        case ($urandom_range(0, 5))
            0: write_reg(CFG_MASK, 40'hFF);
            1: write_reg(CFG_MASK, 40'h1 << $urandom_range(0, 7));
            2: write_reg(CFG_MASK, 40'h0);
            default: write_reg(CFG_MASK, 40'($urandom_range(0, 255)));
        endcase
        write_reg(CFG_WHITE, 40'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0: write_reg(CFG_THRESHOLD, 40'h0);
            1: write_reg(CFG_THRESHOLD, 40'h3FF);
            default: write_reg(CFG_THRESHOLD, 40'($urandom_range(0, 400)));
        endcase
    endtask

    initial begin
        logic [7:0][9:0] s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed scans under reset defaults: extremes, read error, flat scan.
        send_scan('0, 1'b1, 0);
        send_scan('1, 1'b1, 0);
        send_scan({10'd1023, 70'd0}, 1'b1, 0);
        send_scan({70'd0, 10'd1023}, 1'b1, 0);
        send_scan({10'd0, 10'd0, 10'd0, 10'd900, 10'd1000, 10'd900, 10'd0, 10'd0}, 1'b1, 0);
        send_scan(80'($urandom()), 1'b0, 0);
        drain();
        // Zero ranges, white line, high threshold, single channel, empty mask, two end channels.
        write_reg(CFG_RANGE_LOW, 40'h0);
        write_reg(CFG_MIN_LOW, {10'd5, 10'd5, 10'd5, 10'd5});
        write_reg(CFG_WHITE, 40'h1);
        send_scan({40'd0, 10'd6, 10'd4, 10'd6, 10'd5}, 1'b1, 0);
        send_scan('1, 1'b1, 0);
        drain();
        write_reg(CFG_THRESHOLD, 40'h3FF);
        write_reg(CFG_WHITE, 40'h0);
        send_scan({10'd1023, 60'd0, 10'd1023}, 1'b1, 0);
        send_scan({10'd1023, 70'd0}, 1'b1, 0);
        drain();
        write_reg(CFG_THRESHOLD, 40'h0);
        write_reg(CFG_MASK, 40'h10);
        send_scan({70'd0, 10'd500}, 1'b1, 0);
        drain();
        write_reg(CFG_MASK, 40'h0);
        send_scan('1, 1'b1, 0);
        drain();
        write_reg(CFG_MASK, 40'h81);
        write_reg(CFG_MIN_HIGH, 40'h0);
        write_reg(CFG_RANGE_HIGH, 40'd1);
        send_scan({60'd0, 10'd1023, 10'd0}, 1'b1, 0);
        send_scan({60'd0, 10'd0, 10'd1023}, 1'b1, 0);
        drain();

        // Random phases: new settings, then a burst of scans, then a full drain.
        for (int phase = 0; phase < 20; phase++) begin
            random_settings();
            for (int k = 0; k < 50; k++) begin
                for (int c = 0; c < 8; c++) s[c] = 10'($urandom());
                if ($urandom_range(0, 3) == 0)
                    s[$urandom_range(0, 7)] = $urandom_range(0, 1) ? 10'h3FF : 10'h0;
                send_scan(s, $urandom_range(0, 19) != 0, phase % 4 != 1);
                // Hold off the sender once per phase until every result is back.
                if (k == 25) begin
                    i_start <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("tb_line_position_centroid_unit passed");
        else
            $display("tb_line_position_centroid_unit failed");
        $finish;
    end
endmodule

// ----- sim.f -----
design/lpc_pkg.sv
design/lpc_calib.sv
design/lpc_norm.sv
design/lpc_centroid.sv
design/line_position_centroid_unit.sv
tb/lpc_checker.sv
tb/tb_line_position_centroid_unit.sv
